@@ rtl/core/lje_pkg.sv @@
// ----------------------------------------------------------------------------
// lje_pkg
// shared constants and types for the lennard-jones energy sum block
// ----------------------------------------------------------------------------
`default_nettype none

package lje_pkg;

    localparam int MAX_PARTICLES = 128;
    localparam int ADDR_W        = $clog2(MAX_PARTICLES);
    localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);

    localparam int POS_W   = 24;
    localparam int VEL_W   = 32;
    localparam int ENTRY_W = 3 * POS_W;
    localparam int MAG_W   = 26;
    localparam int R_W     = 52;
    localparam int Q_W     = 64;
    localparam int ROOT_W  = 32;
    localparam int DIV_STEPS = 69;

    localparam logic [POS_W-1:0] BOX_RESET = 24'd3355443;
    localparam logic [R_W-1:0]   R_LIMIT   = 52'd8388608;
    localparam logic [63:0]      SPOS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        REG_BOX_X = 2'd0,
        REG_BOX_Y = 2'd1,
        REG_BOX_Z = 2'd2,
        REG_NONE  = 2'd3
    } t_reg;

endpackage

`default_nettype wire

@@ rtl/core/lennard_jones_energy_sum.sv @@
// load: three squares on the shared multiplier and a 32-step sqrt per particle
// last particle: then visits n*(n-1)/2 stored pairs; a pair beyond R_LIMIT uses the
// 69-step divider and twelve partial products on the shared 32x32 multiplier
// one particle at a time; s_axis_tready is high only while idle
// synchronous active-low reset clears count and kinetic sum, resets speed extremes, loads box registers
// ----------------------------------------------------------------------------
// lennard_jones_energy_sum
// stores particles, sums squared speeds and the periodic lennard-jones potential
// ----------------------------------------------------------------------------
`default_nettype none

module lennard_jones_energy_sum import lje_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    input  wire logic [167:0] s_axis_tdata,
    input  wire logic         s_axis_tlast,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // kinetic_sum, potential_sum, min_speed, max_speed
    output logic      [191:0] m_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready
);

    typedef enum logic [3:0] {
        S_IDLE, S_VSQ, S_SQGO, S_SQRT, S_PSTART, S_RDI, S_LDI, S_RDJ,
        S_LDJ, S_ASQ, S_RCHK, S_DIV, S_WM, S_WEND, S_ACC, S_OUT
    } t_state;

    t_state             r_state;
    logic [POS_W-1:0]   r_box [3];
    logic [CNT_W-1:0]   r_cnt, r_i, r_j;
    logic [63:0]        r_kin, r_pot, r_s2, r_term;
    logic [31:0]        r_lo, r_hi;
    logic [31:0]        r_mag [3];
    logic               r_last;
    logic [ENTRY_W-1:0] r_pi;
    logic [MAG_W-1:0]   r_m [3];
    logic [R_W-1:0]     r_r;
    logic [2:0]         r_k;
    logic [1:0]         r_ph;
    logic [63:0]        r_x, r_y, r_u, r_u3;
    logic [127:0]       r_acc;

    logic               w_in_acc, w_keep, w_we;
    logic [ADDR_W-1:0]  w_raddr;
    logic [ENTRY_W-1:0] w_rdata;
    logic [31:0]        w_a, w_b;
    logic [63:0]        w_p;
    logic [127:0]       w_sh;
    logic               w_div_start, w_div_done, w_sq_done;
    logic [Q_W-1:0]     w_quo;
    logic [ROOT_W-1:0]  w_root;
    logic [64:0]        w_kin_sum;
    logic [63:0]        w_pot_sat;
    t_reg               w_reg;

    function automatic logic [31:0] vmag(input logic [31:0] v);
        return v[31] ? 32'(-v) : v;
    endfunction

    function automatic logic [MAG_W-1:0] axis_min(input logic [POS_W-1:0] a,
                                                  input logic [POS_W-1:0] b,
                                                  input logic [POS_W-1:0] box);
        logic signed [26:0] dx, c0, c2;
        logic [26:0]        m0, m1, m2, best;
        dx   = $signed({3'b0, a}) - $signed({3'b0, b});
        c0   = dx - $signed({3'b0, box});
        c2   = dx + $signed({3'b0, box});
        m0   = c0[26] ? 27'(-c0) : 27'(c0);
        m1   = dx[26] ? 27'(-dx) : 27'(dx);
        m2   = c2[26] ? 27'(-c2) : 27'(c2);
        best = m0;
        if (m1 < best) best = m1;
        if (m2 < best) best = m2;
        return best[MAG_W-1:0];
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'b0} : SPOS_MAX;
        end
        return s[63:0];
    endfunction

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign w_reg  = t_reg'(paddr[3:2]);

    always_comb begin
        unique case (w_reg)
            REG_BOX_X: prdata = {8'b0, r_box[0]};
            REG_BOX_Y: prdata = {8'b0, r_box[1]};
            REG_BOX_Z: prdata = {8'b0, r_box[2]};
            default:   prdata = '0;
        endcase
    end

    // ---------------- handshakes ----------------
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_keep        = (r_cnt < CNT_W'(MAX_PARTICLES));
    assign w_we          = w_in_acc && w_keep;
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {r_hi, r_lo, r_pot, r_kin};

    assign w_raddr = (r_state == S_RDI) ? r_i[ADDR_W-1:0] : r_j[ADDR_W-1:0];

    lje_store u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_cnt[ADDR_W-1:0]),
        .i_wdata (s_axis_tdata[ENTRY_W-1:0]),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ---------------- shared multiplier operands ----------------
    always_comb begin
        w_a = '0;
        w_b = '0;
        case (r_state)
            S_VSQ: begin
                case (r_k)
                    3'd0:    begin w_a = r_mag[0]; w_b = r_mag[0]; end
                    3'd1:    begin w_a = r_mag[1]; w_b = r_mag[1]; end
                    3'd2:    begin w_a = r_mag[2]; w_b = r_mag[2]; end
                    default: begin w_a = '0; w_b = '0; end
                endcase
            end
            S_ASQ: begin
                case (r_k)
                    3'd0:    begin w_a = 32'(r_m[0]); w_b = 32'(r_m[0]); end
                    3'd1:    begin w_a = 32'(r_m[1]); w_b = 32'(r_m[1]); end
                    3'd2:    begin w_a = 32'(r_m[2]); w_b = 32'(r_m[2]); end
                    default: begin w_a = '0; w_b = '0; end
                endcase
            end
            S_WM: begin
                case (r_k)
                    3'd0:    begin w_a = r_x[31:0];  w_b = r_y[31:0];  end
                    3'd1:    begin w_a = r_x[31:0];  w_b = r_y[63:32]; end
                    3'd2:    begin w_a = r_x[63:32]; w_b = r_y[31:0];  end
                    3'd3:    begin w_a = r_x[63:32]; w_b = r_y[63:32]; end
                    default: begin w_a = '0; w_b = '0; end
                endcase
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    // partial product placed by the index issued in the previous cycle
    always_comb begin
        case (r_k)
            3'd2, 3'd3: w_sh = {32'b0, w_p, 32'b0};
            3'd4:       w_sh = {w_p, 64'b0};
            default:    w_sh = {64'b0, w_p};
        endcase
    end

    lje_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_p   (w_p)
    );

    assign w_div_start = (r_state == S_RCHK) && (r_r > R_LIMIT);

    lje_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_den   (r_r),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    lje_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_SQGO),
        .i_x     (r_s2),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    assign w_kin_sum = {1'b0, r_kin} + {11'b0, r_s2[63:10]};
    assign w_pot_sat = sat_add(r_pot, r_term);

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_kin   <= '0;
            r_lo    <= '1;
            r_hi    <= '0;
            r_box[0] <= BOX_RESET;
            r_box[1] <= BOX_RESET;
            r_box[2] <= BOX_RESET;
        end else begin
            if (psel && penable && pwrite && pready) begin
                unique case (w_reg)
                    REG_BOX_X: r_box[0] <= pwdata[POS_W-1:0];
                    REG_BOX_Y: r_box[1] <= pwdata[POS_W-1:0];
                    REG_BOX_Z: r_box[2] <= pwdata[POS_W-1:0];
                    default:   ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_mag[0] <= vmag(s_axis_tdata[103:72]);
                        r_mag[1] <= vmag(s_axis_tdata[135:104]);
                        r_mag[2] <= vmag(s_axis_tdata[167:136]);
                        r_last   <= s_axis_tlast;
                        r_s2     <= '0;
                        r_k      <= '0;
                        if (w_keep) begin
                            r_cnt   <= r_cnt + CNT_W'(1);
                            r_state <= S_VSQ;
                        end else begin
                            r_state <= s_axis_tlast ? S_PSTART : S_IDLE;
                        end
                    end
                end
                S_VSQ: begin
                    r_k <= r_k + 3'd1;
                    if (r_k != 3'd0) r_s2 <= r_s2 + w_p;
                    if (r_k == 3'd3) r_state <= S_SQGO;
                end
                S_SQGO: r_state <= S_SQRT;
                S_SQRT: begin
                    if (w_sq_done) begin
                        r_kin <= w_kin_sum[64] ? '1 : w_kin_sum[63:0];
                        if (w_root < r_lo) r_lo <= w_root;
                        if (w_root > r_hi) r_hi <= w_root;
                        r_state <= r_last ? S_PSTART : S_IDLE;
                    end
                end
                S_PSTART: begin
                    r_pot <= '0;
                    r_i   <= '0;
                    r_j   <= CNT_W'(1);
                    r_state <= (r_cnt < CNT_W'(2)) ? S_OUT : S_RDI;
                end
                S_RDI: r_state <= S_LDI;
                S_LDI: begin
                    r_pi    <= w_rdata;
                    r_state <= S_RDJ;
                end
                S_RDJ: r_state <= S_LDJ;
                S_LDJ: begin
                    r_m[0] <= axis_min(r_pi[23:0],  w_rdata[23:0],  r_box[0]);
                    r_m[1] <= axis_min(r_pi[47:24], w_rdata[47:24], r_box[1]);
                    r_m[2] <= axis_min(r_pi[71:48], w_rdata[71:48], r_box[2]);
                    r_r     <= '0;
                    r_k     <= '0;
                    r_state <= S_ASQ;
                end
                S_ASQ: begin
                    r_k <= r_k + 3'd1;
                    if (r_k != 3'd0) r_r <= r_r + w_p[R_W-1:0];
                    if (r_k == 3'd3) r_state <= S_RCHK;
                end
                S_RCHK: begin
                    if (r_r > R_LIMIT) begin
                        r_state <= S_DIV;
                    end else begin
                        r_term  <= SPOS_MAX;
                        r_state <= S_ACC;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_u     <= w_quo;
                        r_x     <= w_quo;
                        r_y     <= w_quo;
                        r_ph    <= 2'd0;
                        r_acc   <= '0;
                        r_k     <= '0;
                        r_state <= S_WM;
                    end
                end
                S_WM: begin
                    r_k <= r_k + 3'd1;
                    if (r_k != 3'd0) r_acc <= r_acc + w_sh;
                    if (r_k == 3'd4) r_state <= S_WEND;
                end
                S_WEND: begin
                    r_acc <= '0;
                    r_k   <= '0;
                    case (r_ph)
                        2'd0, 2'd1: begin
                            if (r_acc[127:96] != 32'd0) begin
                                r_term  <= SPOS_MAX;
                                r_state <= S_ACC;
                            end else begin
                                r_x     <= r_acc[95:32];
                                r_y     <= (r_ph == 2'd0) ? r_u : r_acc[95:32];
                                r_u3    <= r_acc[95:32];
                                r_ph    <= r_ph + 2'd1;
                                r_state <= S_WM;
                            end
                        end
                        default: begin
                            if (r_acc[127:103] != 25'd0) begin
                                r_term <= SPOS_MAX;
                            end else begin
                                r_term <= r_acc[103:40] - {8'b0, r_u3[63:8]};
                            end
                            r_state <= S_ACC;
                        end
                    endcase
                end
                S_ACC: begin
                    r_pot <= w_pot_sat;
                    if (r_j + CNT_W'(1) < r_cnt) begin
                        r_j     <= r_j + CNT_W'(1);
                        r_state <= S_RDJ;
                    end else if (r_i + CNT_W'(2) < r_cnt) begin
                        r_i     <= r_i + CNT_W'(1);
                        r_j     <= r_i + CNT_W'(2);
                        r_state <= S_RDI;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_cnt   <= '0;
                        r_kin   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ---------------- assertions ----------------
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_PARTICLES))
        else $error("particle count above store depth");

    a_out_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready) |=> (r_cnt == '0 && r_kin == '0))
        else $error("set not cleared after result transaction");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input taken while result pending");

endmodule

`default_nettype wire

@@ rtl/core/lje_mul.sv @@
// ----------------------------------------------------------------------------
// lje_mul
// shared 32x32 unsigned multiplier with registered product
// ----------------------------------------------------------------------------
`default_nettype none

module lje_mul import lje_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [63:0] o_p
);

    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

@@ rtl/core/lje_div.sv @@
// ----------------------------------------------------------------------------
// lje_div
// bit-serial restoring divider computing floor(2^68 / r), one bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module lje_div import lje_pkg::*; (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [R_W-1:0] i_den,
    output logic                o_done,
    output logic      [Q_W-1:0] o_quo
);

    logic [R_W-1:0] r_den;
    logic [R_W-1:0] r_rem;
    logic [Q_W-1:0] r_q;
    logic [6:0]     r_idx;
    logic           r_busy;
    logic           r_done;
    logic [R_W:0]   w_sh;
    logic           w_ge;

    assign w_sh = {r_rem, (r_idx == 7'(DIV_STEPS - 1))};
    assign w_ge = (w_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_den  <= i_den;
                r_rem  <= '0;
                r_q    <= '0;
                r_idx  <= 7'(DIV_STEPS - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? R_W'(w_sh - {1'b0, r_den}) : w_sh[R_W-1:0];
                r_q   <= {r_q[Q_W-2:0], w_ge};
                r_idx <= r_idx - 7'd1;
                if (r_idx == 7'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

`default_nettype wire

@@ rtl/core/lje_sqrt.sv @@
// ----------------------------------------------------------------------------
// lje_sqrt
// iterative floor square root of a 64-bit value, two radicand bits a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module lje_sqrt import lje_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [63:0]       i_x,
    output logic                   o_done,
    output logic      [ROOT_W-1:0] o_root
);

    logic [63:0] r_x;
    logic [63:0] r_res;
    logic [4:0]  r_idx;
    logic        r_busy;
    logic        r_done;
    logic [63:0] w_bit;
    logic [63:0] w_t;
    logic        w_ge;

    assign w_bit = 64'd1 << {r_idx, 1'b0};
    assign w_t   = r_res + w_bit;
    assign w_ge  = (r_x >= w_t);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= i_x;
                r_res  <= '0;
                r_idx  <= 5'd31;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (w_ge) begin
                    r_x   <= r_x - w_t;
                    r_res <= (r_res >> 1) + w_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_idx <= r_idx - 5'd1;
                if (r_idx == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[ROOT_W-1:0];

endmodule

`default_nettype wire

@@ rtl/core/lje_store.sv @@
// ----------------------------------------------------------------------------
// lje_store
// particle position memory, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module lje_store import lje_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [ADDR_W-1:0]  i_waddr,
    input  wire logic [ENTRY_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0]  i_raddr,
    output logic      [ENTRY_W-1:0] o_rdata
);

    logic [ENTRY_W-1:0] r_mem [MAX_PARTICLES];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
